/* rtl/csrm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrm_pkg
// shared types and constants of the contiguous span ring manager
// ----------------------------------------------------------------------------
package csrm_pkg;

  localparam int unsigned MAX_SAMPLES = 65536;
  localparam int unsigned MAX_BLOCKS  = 256;

  localparam int unsigned BLK_W  = 9;   // block size, block count, grant blocks
  localparam int unsigned OFF_W  = 16;  // span offset field
  localparam int unsigned SPAN_W = 17;  // positions and span counts
  localparam int unsigned PROD_W = 18;  // blocks times block size
  localparam int unsigned SUM_W  = 19;  // span count plus product

  localparam int unsigned DIV_STEPS = SPAN_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [SPAN_W-1:0] RING_MAX  = SPAN_W'(MAX_SAMPLES);
  localparam logic [BLK_W-1:0]  BLOCK_MAX = BLK_W'(MAX_BLOCKS);

  localparam logic [BLK_W-1:0] BLOCK_SIZE_RST  = BLK_W'(1);
  localparam logic [BLK_W-1:0] BLOCK_COUNT_RST = BLK_W'(256);
  localparam logic [SPAN_W-1:0] RING_RST       = SPAN_W'(256);

  // request codes
  typedef enum logic [1:0] {
    REQ_WR_SPAN   = 2'd0,
    REQ_WR_COMMIT = 2'd1,
    REQ_RD_SPAN   = 2'd2,
    REQ_RD_FREE   = 2'd3
  } req_t;

  // register indexes
  localparam logic REG_BLOCK_SIZE  = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_CHECK = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;      // take the input item
    logic mul;       // form the span product and pick the available span
    logic div_init;  // load the divider
    logic div_step;  // one divider step
    logic finish;    // commit state and write the result register
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage : csrm_pkg
`default_nettype wire

/* rtl/csrm_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrm_regs
// configuration registers, ring length and restart pulse
// ----------------------------------------------------------------------------
module csrm_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [csrm_pkg::BLK_W-1:0]        block_size,
  output logic [csrm_pkg::BLK_W-1:0]        block_count,
  output logic [csrm_pkg::SPAN_W-1:0]       ring_len,
  output logic                              restart
);
  import csrm_pkg::*;

  logic [BLK_W-1:0]  bs_r, bs_nxt;
  logic [BLK_W-1:0]  bc_r, bc_nxt;
  logic [SPAN_W-1:0] len_r, len_nxt;
  logic              restart_r;
  logic              wr_en;
  logic [BLK_W-1:0]  wdata;
  logic [PROD_W-1:0] prod;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign wdata  = pwdata[BLK_W-1:0];

  always_comb begin
    bs_nxt = bs_r;
    bc_nxt = bc_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_BLOCK_SIZE:  bs_nxt = wdata;
        REG_BLOCK_COUNT: bc_nxt = (wdata > BLOCK_MAX) ? BLOCK_MAX : wdata;
        default:         bs_nxt = bs_r;
      endcase
    end
    prod    = PROD_W'(bs_nxt) * PROD_W'(bc_nxt);
    len_nxt = (prod > PROD_W'(RING_MAX)) ? RING_MAX : prod[SPAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r      <= BLOCK_SIZE_RST;
      bc_r      <= BLOCK_COUNT_RST;
      len_r     <= RING_RST;
      restart_r <= 1'b0;
    end else begin
      bs_r      <= bs_nxt;
      bc_r      <= bc_nxt;
      len_r     <= len_nxt;
      restart_r <= wr_en;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_SIZE:  prdata = {{(32-BLK_W){1'b0}}, bs_r};
      REG_BLOCK_COUNT: prdata = {{(32-BLK_W){1'b0}}, bc_r};
      default:         prdata = '0;
    endcase
  end

  assign block_size  = bs_r;
  assign block_count = bc_r;
  assign ring_len    = len_r;
  assign restart     = restart_r;

endmodule : csrm_regs
`default_nettype wire

/* rtl/csrm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrm_ctrl
// sequencer for one item: multiply, check, divide, finish
// ----------------------------------------------------------------------------
module csrm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire csrm_pkg::stat_t  stat,
  output csrm_pkg::cmd_t        cmd
);
  import csrm_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.div_init = 1'b1;
        state_nxt    = stat.need_div ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the result register can take the item
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : csrm_ctrl
`default_nettype wire

/* rtl/csrm_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csrm_dp
// ring state, span product, clamp divider and result register
// ----------------------------------------------------------------------------
module csrm_dp (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire csrm_pkg::cmd_t               cmd,
  output csrm_pkg::stat_t                   stat,
  input  wire logic [csrm_pkg::BLK_W-1:0]   block_size,
  input  wire logic [csrm_pkg::BLK_W-1:0]   block_count,
  input  wire logic [csrm_pkg::SPAN_W-1:0]  ring_len,
  input  wire logic                         restart,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic [csrm_pkg::BLK_W-1:0]   in_count,
  input  wire logic [csrm_pkg::OFF_W-1:0]   in_offset,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_granted,
  output logic [csrm_pkg::OFF_W-1:0]        out_span_offset,
  output logic [csrm_pkg::BLK_W-1:0]        out_span_blocks,
  output logic                              out_accepted,
  output logic [csrm_pkg::SPAN_W-1:0]       out_free_span,
  output logic [csrm_pkg::SPAN_W-1:0]       out_ready_span
);
  import csrm_pkg::*;

  // item operands
  req_t              req_r;
  logic [BLK_W-1:0]  cnt_r;
  logic [OFF_W-1:0]  off_r;
  logic [PROD_W-1:0] prod_r;
  logic [SPAN_W-1:0] avail_r;

  // divider
  logic [SPAN_W-1:0]    dvd_r;
  logic [SPAN_W-1:0]    quo_r;
  logic [BLK_W-1:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [BLK_W:0]       trial;
  logic                 q_bit;

  // ring state
  logic [SPAN_W-1:0] wpos_r, wpos_nxt;
  logic [SPAN_W-1:0] rpos_r, rpos_nxt;
  logic [SPAN_W-1:0] free_r, free_nxt;
  logic [SPAN_W-1:0] ready_r, ready_nxt;
  logic              wg_valid_r, wg_valid_nxt;
  logic [BLK_W-1:0]  wg_blocks_r, wg_blocks_nxt;
  logic [OFF_W-1:0]  wg_off_r, wg_off_nxt;
  logic              rg_valid_r, rg_valid_nxt;
  logic [BLK_W-1:0]  rg_blocks_r, rg_blocks_nxt;
  logic [OFF_W-1:0]  rg_off_r, rg_off_nxt;

  // result
  logic              out_valid_r;
  logic              granted_nxt, accepted_nxt;
  logic [OFF_W-1:0]  span_off_nxt;
  logic [BLK_W-1:0]  span_blk_nxt;

  logic              usable;
  logic              over;
  logic [BLK_W-1:0]  g;
  logic [BLK_W-1:0]  mul_blocks;
  logic [SUM_W-1:0]  full_w;
  logic [SUM_W-1:0]  wsum, rsum, ready_add, free_add;
  logic [SPAN_W-1:0] ready_sat, free_sat, free_sub, ready_sub;

  assign usable = (block_size != '0) && (block_count != '0);
  assign over   = prod_r > PROD_W'(avail_r);
  assign g      = over ? quo_r[BLK_W-1:0] : cnt_r;

  assign stat.need_div = (req_r == REQ_WR_SPAN || req_r == REQ_RD_SPAN) && usable && over;
  assign stat.div_last = div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1);
  assign stat.out_free = !out_valid_r || !out_stall;

  // operand for the shared multiplier
  always_comb begin
    unique case (req_r)
      REQ_WR_COMMIT: mul_blocks = wg_blocks_r;
      REQ_RD_FREE:   mul_blocks = rg_blocks_r;
      default:       mul_blocks = cnt_r;
    endcase
  end

  // restoring divider step
  assign trial = {rem_r, dvd_r[SPAN_W-1]};
  assign q_bit = trial >= {1'b0, block_size};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_t'(in_req_type);
      cnt_r <= in_count;
      off_r <= in_offset;
    end
    if (cmd.mul) begin
      prod_r  <= PROD_W'(mul_blocks) * PROD_W'(block_size);
      avail_r <= (req_r == REQ_RD_SPAN) ? ready_r : free_r;
    end
    if (cmd.div_init) begin
      dvd_r     <= avail_r;
      quo_r     <= '0;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r     <= {dvd_r[SPAN_W-2:0], 1'b0};
      quo_r     <= {quo_r[SPAN_W-2:0], q_bit};
      rem_r     <= q_bit ? BLK_W'(trial - {1'b0, block_size}) : trial[BLK_W-1:0];
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // saturating span arithmetic
  always_comb begin
    full_w    = SUM_W'(ring_len);
    wsum      = SUM_W'(wpos_r) + SUM_W'(prod_r);
    rsum      = SUM_W'(rpos_r) + SUM_W'(prod_r);
    ready_add = SUM_W'(ready_r) + SUM_W'(prod_r);
    free_add  = SUM_W'(free_r) + SUM_W'(prod_r);
    ready_sat = (ready_add > full_w) ? ring_len : ready_add[SPAN_W-1:0];
    free_sat  = (free_add > full_w) ? ring_len : free_add[SPAN_W-1:0];
    free_sub  = (PROD_W'(free_r) > prod_r) ? SPAN_W'(PROD_W'(free_r) - prod_r) : '0;
    ready_sub = (PROD_W'(ready_r) > prod_r) ? SPAN_W'(PROD_W'(ready_r) - prod_r) : '0;
  end

  // state update of one item
  always_comb begin
    wpos_nxt      = wpos_r;
    rpos_nxt      = rpos_r;
    free_nxt      = free_r;
    ready_nxt     = ready_r;
    wg_valid_nxt  = wg_valid_r;
    wg_blocks_nxt = wg_blocks_r;
    wg_off_nxt    = wg_off_r;
    rg_valid_nxt  = rg_valid_r;
    rg_blocks_nxt = rg_blocks_r;
    rg_off_nxt    = rg_off_r;
    granted_nxt   = 1'b0;
    accepted_nxt  = 1'b0;
    span_off_nxt  = '0;
    span_blk_nxt  = '0;
    unique case (req_r)
      REQ_WR_SPAN: begin
        if (usable) begin
          if (g == '0) begin
            wg_valid_nxt = 1'b0;
          end else begin
            wg_valid_nxt  = 1'b1;
            wg_blocks_nxt = g;
            wg_off_nxt    = wpos_r[OFF_W-1:0];
            granted_nxt   = 1'b1;
            span_off_nxt  = wpos_r[OFF_W-1:0];
            span_blk_nxt  = g;
          end
        end
      end
      REQ_RD_SPAN: begin
        if (usable) begin
          if (g == '0) begin
            rg_valid_nxt = 1'b0;
          end else begin
            rg_valid_nxt  = 1'b1;
            rg_blocks_nxt = g;
            rg_off_nxt    = rpos_r[OFF_W-1:0];
            granted_nxt   = 1'b1;
            span_off_nxt  = rpos_r[OFF_W-1:0];
            span_blk_nxt  = g;
          end
        end
      end
      REQ_WR_COMMIT: begin
        if (wg_valid_r && wg_off_r == off_r) begin
          accepted_nxt = 1'b1;
          if (wpos_r >= rpos_r) begin
            ready_nxt = ready_sat;
          end
          // end of ring: writer wraps, free span runs up to the reader
          if (wsum >= full_w) begin
            wpos_nxt = '0;
            free_nxt = rpos_r;
          end else begin
            wpos_nxt = wsum[SPAN_W-1:0];
            free_nxt = free_sub;
          end
        end
      end
      REQ_RD_FREE: begin
        if (rg_valid_r && rg_off_r == off_r) begin
          accepted_nxt = 1'b1;
          if (rpos_r >= wpos_r) begin
            free_nxt = free_sat;
          end
          if (rsum >= full_w) begin
            rpos_nxt  = '0;
            ready_nxt = wpos_r;
          end else begin
            rpos_nxt  = rsum[SPAN_W-1:0];
            ready_nxt = ready_sub;
          end
        end
      end
      default: granted_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      wpos_r     <= '0;
      rpos_r     <= '0;
      free_r     <= restart ? ring_len : RING_RST;
      ready_r    <= '0;
      wg_valid_r <= 1'b0;
      rg_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      wpos_r     <= wpos_nxt;
      rpos_r     <= rpos_nxt;
      free_r     <= free_nxt;
      ready_r    <= ready_nxt;
      wg_valid_r <= wg_valid_nxt;
      rg_valid_r <= rg_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      wg_blocks_r <= wg_blocks_nxt;
      wg_off_r    <= wg_off_nxt;
      rg_blocks_r <= rg_blocks_nxt;
      rg_off_r    <= rg_off_nxt;
      out_granted     <= granted_nxt;
      out_span_offset <= span_off_nxt;
      out_span_blocks <= span_blk_nxt;
      out_accepted    <= accepted_nxt;
      out_free_span   <= free_nxt;
      out_ready_span  <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule : csrm_dp
`default_nettype wire

/* rtl/contiguous_span_ring_manager_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// contiguous_span_ring_manager_top
// block-granular ring manager that hands out contiguous write and read spans
// ----------------------------------------------------------------------------
// Tracks a write position and a read position in a ring of block_size times
// block_count samples (capped at 65536) and answers one item at a time with
// one result item. Each item steps through the multiply, check and finish
// states before the next acceptance; a request that has to be clamped to the
// available span also passes the divide state, which divides the available
// sample count by the block size in a restoring divider that resolves one
// quotient bit per cycle. A finished result sits in an output register, so
// the next item is taken while it waits; a second result waits in the finish
// state until that register drains. Any write of block_size or block_count
// restarts the ring empty in the cycle after the write; the user must write
// the registers only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module contiguous_span_ring_manager_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input items
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   in_req_type,
  input  wire logic [8:0]   in_count,
  input  wire logic [15:0]  in_offset,
  // result items
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              out_granted,
  output logic [15:0]       out_span_offset,
  output logic [8:0]        out_span_blocks,
  output logic              out_accepted,
  output logic [16:0]       out_free_span,
  output logic [16:0]       out_ready_span,
  // register port: block_size at 0x0, block_count at 0x4
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import csrm_pkg::*;

  logic [BLK_W-1:0]  block_size;
  logic [BLK_W-1:0]  block_count;
  logic [SPAN_W-1:0] ring_len;
  logic              restart;
  cmd_t              cmd;
  stat_t             stat;

  // configuration registers and derived ring length
  csrm_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .block_size  (block_size),
    .block_count (block_count),
    .ring_len    (ring_len),
    .restart     (restart)
  );

  // sequencer: owns the input handshake and steps the datapath
  csrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring state, shared multiplier, clamp divider, result register
  csrm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .block_size      (block_size),
    .block_count     (block_count),
    .ring_len        (ring_len),
    .restart         (restart),
    .in_req_type     (in_req_type),
    .in_count        (in_count),
    .in_offset       (in_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_granted     (out_granted),
    .out_span_offset (out_span_offset),
    .out_span_blocks (out_span_blocks),
    .out_accepted    (out_accepted),
    .out_free_span   (out_free_span),
    .out_ready_span  (out_ready_span)
  );

endmodule : contiguous_span_ring_manager_top
`default_nettype wire
